// ===== src/rational_arithmetic_unit_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared implication forms used by the checker module.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_MACROS_SVH

// same-cycle implication
`define RAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rau assertion failed");

// next-cycle implication
`define RAU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rau assertion failed");

`endif

// ===== src/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Types and codes shared by the rational arithmetic unit modules.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int W = 64;

    localparam logic [2:0] KIND_ADD = 3'd0;
    localparam logic [2:0] KIND_SUB = 3'd1;
    localparam logic [2:0] KIND_MUL = 3'd2;
    localparam logic [2:0] KIND_DIV = 3'd3;
    localparam logic [2:0] KIND_NEG = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

    localparam logic DV_DIV = 1'b0;
    localparam logic DV_GCD = 1'b1;

    typedef struct packed {
        logic         start;
        logic         mode;
        logic [W-1:0] a;
        logic [W-1:0] b;
    } t_dv_req;

    typedef struct packed {
        logic         done;
        logic [W-1:0] res;
    } t_dv_rsp;

    typedef struct packed {
        logic         start;
        logic         neg;
        logic [W-1:0] a;
        logic [W-1:0] b;
    } t_mu_req;

    typedef struct packed {
        logic         done;
        logic         fit;
        logic [W-1:0] prod;
    } t_mu_rsp;

endpackage

// ===== src/rau_divgcd.sv =====
// ----------------------------------------------------------------------------
// rau_divgcd
// Restoring divider, one quotient bit per cycle; in GCD mode it repeats
// remainder steps (Euclid) until the divisor reaches zero.
// ----------------------------------------------------------------------------
module rau_divgcd
    import rau_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dv_req i_req,
    output t_dv_rsp o_rsp
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_CHK  = 2'd1;
    localparam logic [1:0] D_RUN  = 2'd2;

    logic [1:0]   r_st;
    logic         r_mode;
    logic [W-1:0] r_x;
    logic [W-1:0] r_y;
    logic [W-1:0] r_dvd;
    logic [W-1:0] r_rem;
    logic [5:0]   r_cnt;
    logic         r_done;
    logic [W-1:0] r_res;

    logic [W:0]   rem_sh;
    logic         qbit;
    logic [W-1:0] rem_nx;
    logic [W-1:0] dvd_nx;

    always_comb begin
        rem_sh = {r_rem, r_dvd[W-1]};
        qbit   = rem_sh >= {1'b0, r_y};
        rem_nx = qbit ? W'(rem_sh - {1'b0, r_y}) : rem_sh[W-1:0];
        dvd_nx = {r_dvd[W-2:0], qbit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= D_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                D_IDLE: begin
                    if (i_req.start) begin
                        r_mode <= i_req.mode;
                        r_x    <= i_req.a;
                        r_y    <= i_req.b;
                        r_dvd  <= i_req.a;
                        r_rem  <= '0;
                        r_cnt  <= '0;
                        r_st   <= (i_req.mode == DV_GCD) ? D_CHK : D_RUN;
                    end
                end
                D_CHK: begin
                    if (r_y == '0) begin
                        r_res  <= r_x;
                        r_done <= 1'b1;
                        r_st   <= D_IDLE;
                    end else begin
                        r_dvd <= r_x;
                        r_rem <= '0;
                        r_cnt <= '0;
                        r_st  <= D_RUN;
                    end
                end
                D_RUN: begin
                    r_rem <= rem_nx;
                    r_dvd <= dvd_nx;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        if (r_mode == DV_GCD) begin
                            r_x  <= r_y;
                            r_y  <= rem_nx;
                            r_st <= D_CHK;
                        end else begin
                            r_res  <= dvd_nx;
                            r_done <= 1'b1;
                            r_st   <= D_IDLE;
                        end
                    end
                end
                default: r_st <= D_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_res;

endmodule

// ===== src/rau_mulchk.sv =====
// ----------------------------------------------------------------------------
// rau_mulchk
// Shift-add 64x64 multiplier, one bit per cycle, with a range check of the
// full product against 2^63-1 (positive) or 2^63 (negative result).
// ----------------------------------------------------------------------------
module rau_mulchk
    import rau_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_mu_req i_req,
    output t_mu_rsp o_rsp
);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_RUN  = 2'd1;
    localparam logic [1:0] M_FIN  = 2'd2;

    logic [1:0]     r_st;
    logic [2*W-1:0] r_p;
    logic [W-1:0]   r_x;
    logic           r_neg;
    logic [5:0]     r_cnt;
    logic           r_done;
    logic           r_fit;
    logic [W-1:0]   r_prod;

    logic [W:0] sum;

    assign sum = r_p[0] ? ({1'b0, r_p[2*W-1:W]} + {1'b0, r_x}) : {1'b0, r_p[2*W-1:W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= M_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_st)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_p   <= {{W{1'b0}}, i_req.b};
                        r_x   <= i_req.a;
                        r_neg <= i_req.neg;
                        r_cnt <= '0;
                        r_st  <= M_RUN;
                    end
                end
                M_RUN: begin
                    r_p   <= {sum, r_p[W-1:1]};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd63) begin
                        r_st <= M_FIN;
                    end
                end
                M_FIN: begin
                    r_prod <= r_p[W-1:0];
                    r_fit  <= (r_p[2*W-1:W] == '0) &&
                              (!r_p[W-1] || (r_neg && r_p[W-2:0] == '0));
                    r_done <= 1'b1;
                    r_st   <= M_IDLE;
                end
                default: r_st <= M_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.fit  = r_fit;
    assign o_rsp.prod = r_prod;

endmodule

// ===== src/rational_arithmetic_unit_core.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Add, subtract, multiply, divide or negate fractions (other codes pass A through), result in lowest terms.
// ----------------------------------------------------------------------------
// One request at a time. A sequencer drives a shared divider/GCD unit (one
// quotient bit per cycle, Euclid by repeated remainders) and a shift-add
// multiplier (one bit per cycle). s_axis_tready is high only while the
// sequencer is idle; a finished result waits in the output register while
// the next request is taken.
module rational_arithmetic_unit_core
    import rau_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_num[63:0], a_den[126:64], b_num[190:127], b_den[253:191], zero pad
    input  logic [255:0] s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // res_num[63:0], res_den[126:64], zero pad
    output logic [127:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_CHK  = 5'd1;
    localparam logic [4:0] S_GA   = 5'd2;
    localparam logic [4:0] S_DA1  = 5'd3;
    localparam logic [4:0] S_DA2  = 5'd4;
    localparam logic [4:0] S_GB   = 5'd5;
    localparam logic [4:0] S_DB1  = 5'd6;
    localparam logic [4:0] S_DB2  = 5'd7;
    localparam logic [4:0] S_SEL  = 5'd8;
    localparam logic [4:0] S_AG   = 5'd9;
    localparam logic [4:0] S_AQ1  = 5'd10;
    localparam logic [4:0] S_AQ2  = 5'd11;
    localparam logic [4:0] S_AM1  = 5'd12;
    localparam logic [4:0] S_AM2  = 5'd13;
    localparam logic [4:0] S_AM3  = 5'd14;
    localparam logic [4:0] S_ASUM = 5'd15;
    localparam logic [4:0] S_XG1  = 5'd16;
    localparam logic [4:0] S_XG2  = 5'd17;
    localparam logic [4:0] S_XD1  = 5'd18;
    localparam logic [4:0] S_XD2  = 5'd19;
    localparam logic [4:0] S_XD3  = 5'd20;
    localparam logic [4:0] S_XD4  = 5'd21;
    localparam logic [4:0] S_XM1  = 5'd22;
    localparam logic [4:0] S_XM2  = 5'd23;
    localparam logic [4:0] S_UNA  = 5'd24;
    localparam logic [4:0] S_RG   = 5'd25;
    localparam logic [4:0] S_RD1  = 5'd26;
    localparam logic [4:0] S_RD2  = 5'd27;
    localparam logic [4:0] S_FIN  = 5'd28;

    logic [4:0]   r_state;
    logic         r_issued;
    logic [2:0]   r_kind;
    logic [W-1:0] r_an, r_ad, r_bn, r_bd;
    logic         r_aneg, r_bneg;
    logic [W-1:0] r_g, r_h, r_q1, r_q2, r_m1, r_m2;
    logic [W-1:0] r_rmag, r_rden;
    logic         r_rneg;
    logic [1:0]   r_status;

    logic         r_ovalid;
    logic [63:0]  r_onum;
    logic [62:0]  r_oden;
    logic [1:0]   r_ostat;

    t_dv_req dv_req;
    t_dv_rsp dv_rsp;
    t_mu_req mu_req;
    t_mu_rsp mu_rsp;

    logic       is_mul;
    logic [W:0] add_sum;
    logic [W:0] add_lim;
    logic       s1, s2;
    logic [63:0] in_an, in_bn;

    rau_divgcd u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (dv_req),
        .o_rsp   (dv_rsp)
    );

    rau_mulchk u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mu_req),
        .o_rsp   (mu_rsp)
    );

    assign is_mul = (r_kind == KIND_MUL);

    // operand selection for the shared units
    always_comb begin
        dv_req.start = 1'b0;
        dv_req.mode  = DV_DIV;
        dv_req.a     = r_an;
        dv_req.b     = r_g;
        mu_req.start = 1'b0;
        mu_req.neg   = 1'b0;
        mu_req.a     = r_an;
        mu_req.b     = r_q1;
        unique case (r_state)
            S_GA:  begin dv_req.start = !r_issued; dv_req.mode = DV_GCD;
                         dv_req.a = r_an; dv_req.b = r_ad; end
            S_DA1: begin dv_req.start = !r_issued; dv_req.a = r_an; dv_req.b = r_g; end
            S_DA2: begin dv_req.start = !r_issued; dv_req.a = r_ad; dv_req.b = r_g; end
            S_GB:  begin dv_req.start = !r_issued; dv_req.mode = DV_GCD;
                         dv_req.a = r_bn; dv_req.b = r_bd; end
            S_DB1: begin dv_req.start = !r_issued; dv_req.a = r_bn; dv_req.b = r_g; end
            S_DB2: begin dv_req.start = !r_issued; dv_req.a = r_bd; dv_req.b = r_g; end
            S_AG:  begin dv_req.start = !r_issued; dv_req.mode = DV_GCD;
                         dv_req.a = r_ad; dv_req.b = r_bd; end
            S_AQ1: begin dv_req.start = !r_issued; dv_req.a = r_bd; dv_req.b = r_g; end
            S_AQ2: begin dv_req.start = !r_issued; dv_req.a = r_ad; dv_req.b = r_g; end
            S_XG1: begin dv_req.start = !r_issued; dv_req.mode = DV_GCD;
                         dv_req.a = r_an; dv_req.b = is_mul ? r_bd : r_bn; end
            S_XG2: begin dv_req.start = !r_issued; dv_req.mode = DV_GCD;
                         dv_req.a = is_mul ? r_bn : r_ad;
                         dv_req.b = is_mul ? r_ad : r_bd; end
            S_XD1: begin dv_req.start = !r_issued; dv_req.a = r_an; dv_req.b = r_g; end
            S_XD2: begin dv_req.start = !r_issued;
                         dv_req.a = is_mul ? r_bd : r_bn; dv_req.b = r_g; end
            S_XD3: begin dv_req.start = !r_issued;
                         dv_req.a = is_mul ? r_bn : r_ad; dv_req.b = r_h; end
            S_XD4: begin dv_req.start = !r_issued;
                         dv_req.a = is_mul ? r_ad : r_bd; dv_req.b = r_h; end
            S_RG:  begin dv_req.start = !r_issued; dv_req.mode = DV_GCD;
                         dv_req.a = r_rmag; dv_req.b = r_rden; end
            S_RD1: begin dv_req.start = !r_issued; dv_req.a = r_rmag; dv_req.b = r_g; end
            S_RD2: begin dv_req.start = !r_issued; dv_req.a = r_rden; dv_req.b = r_g; end
            S_AM1: begin mu_req.start = !r_issued; mu_req.neg = r_aneg;
                         mu_req.a = r_an; mu_req.b = r_q1; end
            S_AM2: begin mu_req.start = !r_issued; mu_req.neg = r_bneg;
                         mu_req.a = r_bn; mu_req.b = r_q2; end
            S_AM3: begin mu_req.start = !r_issued;
                         mu_req.a = r_ad; mu_req.b = r_q1; end
            S_XM1: begin mu_req.start = !r_issued; mu_req.neg = r_rneg;
                         mu_req.a = r_an; mu_req.b = is_mul ? r_bn : r_bd; end
            S_XM2: begin mu_req.start = !r_issued;
                         mu_req.a = r_ad; mu_req.b = is_mul ? r_bd : r_bn; end
            default: ;
        endcase
    end

    // signed add of the two scaled numerators
    always_comb begin
        s1      = r_aneg;
        s2      = r_bneg ^ (r_kind == KIND_SUB);
        add_sum = {1'b0, r_m1} + {1'b0, r_m2};
        add_lim = s1 ? {2'b01, {(W-1){1'b0}}} : {2'b00, {(W-1){1'b1}}};
    end

    assign in_an = s_axis_tdata[63] ? (64'd0 - s_axis_tdata[63:0]) : s_axis_tdata[63:0];
    assign in_bn = s_axis_tdata[190] ? (64'd0 - s_axis_tdata[190:127])
                                     : s_axis_tdata[190:127];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_issued <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (dv_req.start || mu_req.start) begin
                r_issued <= 1'b1;
            end
            if (dv_rsp.done || mu_rsp.done) begin
                r_issued <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_kind   <= s_axis_tuser;
                        r_an     <= in_an;
                        r_aneg   <= s_axis_tdata[63];
                        r_ad     <= {1'b0, s_axis_tdata[126:64]};
                        r_bn     <= in_bn;
                        r_bneg   <= s_axis_tdata[190];
                        r_bd     <= {1'b0, s_axis_tdata[253:191]};
                        r_status <= ST_OK;
                        r_state  <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_ad == '0 || (r_kind <= KIND_DIV && r_bd == '0)) begin
                        r_status <= ST_DIVZ;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_GA;
                    end
                end
                S_GA:  if (dv_rsp.done) begin r_g <= dv_rsp.res; r_state <= S_DA1; end
                S_DA1: if (dv_rsp.done) begin
                    r_an <= dv_rsp.res;
                    if (dv_rsp.res == '0) r_aneg <= 1'b0;
                    r_state <= S_DA2;
                end
                S_DA2: if (dv_rsp.done) begin
                    r_ad    <= dv_rsp.res;
                    r_state <= (r_kind <= KIND_DIV) ? S_GB : S_UNA;
                end
                S_GB:  if (dv_rsp.done) begin r_g <= dv_rsp.res; r_state <= S_DB1; end
                S_DB1: if (dv_rsp.done) begin
                    r_bn <= dv_rsp.res;
                    if (dv_rsp.res == '0) r_bneg <= 1'b0;
                    r_state <= S_DB2;
                end
                S_DB2: if (dv_rsp.done) begin r_bd <= dv_rsp.res; r_state <= S_SEL; end
                S_SEL: begin
                    r_rneg <= r_aneg ^ r_bneg;
                    case (r_kind)
                        KIND_ADD, KIND_SUB: r_state <= S_AG;
                        KIND_MUL:           r_state <= S_XG1;
                        default: begin
                            if (r_bn == '0) begin
                                r_status <= ST_DIVZ;
                                r_state  <= S_FIN;
                            end else begin
                                r_state <= S_XG1;
                            end
                        end
                    endcase
                end
                S_AG:  if (dv_rsp.done) begin r_g  <= dv_rsp.res; r_state <= S_AQ1; end
                S_AQ1: if (dv_rsp.done) begin r_q1 <= dv_rsp.res; r_state <= S_AQ2; end
                S_AQ2: if (dv_rsp.done) begin r_q2 <= dv_rsp.res; r_state <= S_AM1; end
                S_AM1: if (mu_rsp.done) begin
                    r_m1 <= mu_rsp.prod;
                    if (!mu_rsp.fit) begin r_status <= ST_OVF; r_state <= S_FIN; end
                    else r_state <= S_AM2;
                end
                S_AM2: if (mu_rsp.done) begin
                    r_m2 <= mu_rsp.prod;
                    if (!mu_rsp.fit) begin r_status <= ST_OVF; r_state <= S_FIN; end
                    else r_state <= S_AM3;
                end
                S_AM3: if (mu_rsp.done) begin
                    r_rden <= mu_rsp.prod;
                    if (!mu_rsp.fit) begin r_status <= ST_OVF; r_state <= S_FIN; end
                    else r_state <= S_ASUM;
                end
                S_ASUM: begin
                    if (s1 == s2) begin
                        if (add_sum > add_lim) begin
                            r_status <= ST_OVF;
                            r_state  <= S_FIN;
                        end else begin
                            r_rmag  <= add_sum[W-1:0];
                            r_rneg  <= s1;
                            r_state <= S_RG;
                        end
                    end else begin
                        if (r_m1 >= r_m2) begin
                            r_rmag <= r_m1 - r_m2;
                            r_rneg <= s1;
                        end else begin
                            r_rmag <= r_m2 - r_m1;
                            r_rneg <= s2;
                        end
                        r_state <= S_RG;
                    end
                end
                S_XG1: if (dv_rsp.done) begin r_g <= dv_rsp.res; r_state <= S_XG2; end
                S_XG2: if (dv_rsp.done) begin r_h <= dv_rsp.res; r_state <= S_XD1; end
                S_XD1: if (dv_rsp.done) begin r_an <= dv_rsp.res; r_state <= S_XD2; end
                S_XD2: if (dv_rsp.done) begin
                    if (is_mul) r_bd <= dv_rsp.res;
                    else        r_bn <= dv_rsp.res;
                    r_state <= S_XD3;
                end
                S_XD3: if (dv_rsp.done) begin
                    if (is_mul) r_bn <= dv_rsp.res;
                    else        r_ad <= dv_rsp.res;
                    r_state <= S_XD4;
                end
                S_XD4: if (dv_rsp.done) begin
                    if (is_mul) r_ad <= dv_rsp.res;
                    else        r_bd <= dv_rsp.res;
                    r_state <= S_XM1;
                end
                S_XM1: if (mu_rsp.done) begin
                    r_rmag <= mu_rsp.prod;
                    if (!mu_rsp.fit) begin r_status <= ST_OVF; r_state <= S_FIN; end
                    else r_state <= S_XM2;
                end
                S_XM2: if (mu_rsp.done) begin
                    r_rden <= mu_rsp.prod;
                    if (!mu_rsp.fit) begin r_status <= ST_OVF; r_state <= S_FIN; end
                    else r_state <= S_RG;
                end
                S_UNA: begin
                    // negate flips the sign; other unary codes pass the operand
                    r_rmag <= r_an;
                    r_rden <= r_ad;
                    if (r_kind == KIND_NEG) begin
                        r_rneg <= !r_aneg;
                        // -2^63 has no positive counterpart
                        if (r_aneg && r_an[W-1]) begin
                            r_status <= ST_OVF;
                            r_state  <= S_FIN;
                        end else begin
                            r_state <= S_RG;
                        end
                    end else begin
                        r_rneg  <= r_aneg;
                        r_state <= S_RG;
                    end
                end
                S_RG:  if (dv_rsp.done) begin r_g <= dv_rsp.res; r_state <= S_RD1; end
                S_RD1: if (dv_rsp.done) begin
                    r_rmag <= dv_rsp.res;
                    if (dv_rsp.res == '0) r_rneg <= 1'b0;
                    r_state <= S_RD2;
                end
                S_RD2: if (dv_rsp.done) begin r_rden <= dv_rsp.res; r_state <= S_FIN; end
                S_FIN: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_ostat  <= r_status;
                        if (r_status != ST_OK) begin
                            r_onum <= '0;
                            r_oden <= 63'd1;
                        end else begin
                            r_onum <= r_rneg ? (64'd0 - r_rmag) : r_rmag;
                            r_oden <= r_rden[62:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_oden, r_onum};
    assign m_axis_tuser  = r_ostat;

endmodule

// ===== src/rau_checker.sv =====
// ----------------------------------------------------------------------------
// rau_port_props
// Port-level checks for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_core_macros.svh"

module rau_port_props
    import rau_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // a held result stays put
    `RAU_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // error results carry 0/1
    `RAU_ASSERT_IMP(a_err_val, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser != ST_OK, m_axis_tdata[63:0] == 64'd0 && m_axis_tdata[126:64] == 63'd1)

    // good results have a nonzero denominator
    `RAU_ASSERT_IMP(a_den_nz, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser == ST_OK, m_axis_tdata[126:64] != 63'd0)

    // one request at a time
    `RAU_ASSERT_NXT(a_busy, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind rational_arithmetic_unit_core rau_port_props u_rau_port_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
